>>> design/ism_pkg.sv
// types and constants for the integer stack machine
// shared by integer_stack_machine; no dependencies
package ism_pkg;

    localparam int WORD_W = 32;

    localparam logic [2:0] ACT_PUSH  = 3'd0;
    localparam logic [2:0] ACT_POP   = 3'd1;
    localparam logic [2:0] ACT_PEEK  = 3'd2;
    localparam logic [2:0] ACT_ADD   = 3'd3;
    localparam logic [2:0] ACT_SUB   = 3'd4;
    localparam logic [2:0] ACT_MUL   = 3'd5;
    localparam logic [2:0] ACT_DIV   = 3'd6;
    localparam logic [2:0] ACT_DRAIN = 3'd7;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [WORD_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_value;
        logic [2:0]               status;
        logic                     last;
    } res_t;

endpackage

>>> design/integer_stack_machine.sv
// integer stack machine: one instruction per beat on a stack held in a synchronous ram
// div uses a 32-step restoring divider
// drain: one result per stored entry, one per cycle while the output is not stalled, read one ahead from the stack ram
// one instruction at a time; the result register lets the next beat in while a result waits
// reset (rst_n, async low) empties the stack; ram contents are not cleared
// depends on ism_pkg
module integer_stack_machine #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  ism_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output ism_pkg::res_t res
);
    import ism_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DCW = $clog2(WORD_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD1,
        S_RD2,
        S_DIV,
        S_DIVFIN,
        S_WB,
        S_OUT,
        S_DRN
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic [CW-1:0]     count_reg;
    logic [2:0]        act_reg;
    logic [WORD_W-1:0] val_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] r_reg;
    logic [AW-1:0]     idx_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              pend_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic              out_free;
    logic              res_load;
    logic              is_binop;
    logic              full;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              drn_last;
    logic [WORD_W:0]   rem_sh;
    logic              rem_ge;
    logic [WORD_W-1:0] b_abs;
    logic [WORD_W-1:0] a_abs;

    assign out_free  = !res_valid_reg || !res_stall;
    assign res_load  = out_free && ((state_reg == S_OUT) || (state_reg == S_DRN));
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign is_binop = (act_reg == ACT_ADD) || (act_reg == ACT_SUB)
                   || (act_reg == ACT_MUL) || (act_reg == ACT_DIV);
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign drn_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // one restoring step of the divider
    assign rem_sh = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    assign a_abs = a_reg[WORD_W-1] ? (~a_reg + WORD_W'(1)) : a_reg;
    assign b_abs = rd_data_reg[WORD_W-1] ? (~rd_data_reg + WORD_W'(1)) : rd_data_reg;

    // stack ram: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // ram access and next state
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = cnt_m1[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = val_reg;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (act_reg)
                    ACT_PUSH:
                    begin
                        wr_en      = !full;
                        state_next = S_OUT;
                    end
                    ACT_POP, ACT_PEEK:
                    begin
                        rd_en      = (count_reg != '0);
                        state_next = (count_reg != '0) ? S_RD1 : S_OUT;
                    end
                    ACT_DRAIN:
                    begin
                        rd_en      = (count_reg != '0);
                        rd_addr    = '0;
                        state_next = (count_reg != '0) ? S_DRN : S_OUT;
                    end
                    default:
                    begin
                        rd_en      = (count_reg >= CW'(2));
                        state_next = (count_reg >= CW'(2)) ? S_RD1 : S_OUT;
                    end
                endcase
            end
            S_RD1:
            begin
                if (is_binop)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_m2[AW-1:0];
                    state_next = S_RD2;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RD2:
            begin
                if (act_reg == ACT_DIV)
                begin
                    state_next = (rd_data_reg == '0) ? S_OUT : S_DIV;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == DCW'(WORD_W - 1))
                begin
                    state_next = S_DIVFIN;
                end
            end
            S_DIVFIN:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = cnt_m2[AW-1:0];
                wr_data    = r_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRN:
            begin
                if (out_free)
                begin
                    if (drn_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // fetch the next entry while this one leaves
                        rd_en   = 1'b1;
                        rd_addr = AW'(CW'(idx_reg) + CW'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            pend_reg      <= '0;
            act_reg       <= '0;
            val_reg       <= '0;
            a_reg         <= '0;
            r_reg         <= '0;
            idx_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            neg_reg       <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        act_reg <= cmd.action;
                        val_reg <= cmd.push_value;
                    end
                end
                S_EXEC:
                begin
                    pend_reg.last <= 1'b1;
                    case (act_reg)
                        ACT_PUSH:
                        begin
                            if (full)
                            begin
                                pend_reg.out_value <= '0;
                                pend_reg.status    <= ST_OVER;
                            end
                            else
                            begin
                                count_reg          <= count_reg + CW'(1);
                                pend_reg.out_value <= val_reg;
                                pend_reg.status    <= ST_OK;
                            end
                        end
                        ACT_POP, ACT_PEEK:
                        begin
                            pend_reg.out_value <= '0;
                            pend_reg.status    <= ST_UNDER;
                        end
                        ACT_DRAIN:
                        begin
                            idx_reg            <= '0;
                            pend_reg.out_value <= '0;
                            pend_reg.status    <= ST_EMPTY;
                        end
                        default:
                        begin
                            pend_reg.out_value <= '0;
                            pend_reg.status    <= ST_UNDER;
                        end
                    endcase
                end
                S_RD1:
                begin
                    if (is_binop)
                    begin
                        a_reg <= rd_data_reg;
                    end
                    else
                    begin
                        pend_reg.out_value <= rd_data_reg;
                        pend_reg.status    <= ST_OK;
                        if (act_reg == ACT_POP)
                        begin
                            count_reg <= cnt_m1;
                        end
                    end
                end
                S_RD2:
                begin
                    case (act_reg)
                        ACT_ADD: r_reg <= a_reg + rd_data_reg;
                        ACT_SUB: r_reg <= a_reg - rd_data_reg;
                        ACT_MUL: r_reg <= a_reg * rd_data_reg;
                        default:
                        begin
                            pend_reg.out_value <= '0;
                            pend_reg.status    <= ST_DIVZ;
                            quo_reg            <= a_abs;
                            dvs_reg            <= b_abs;
                            rem_reg            <= '0;
                            neg_reg            <= a_reg[WORD_W-1] ^ rd_data_reg[WORD_W-1];
                            dcnt_reg           <= '0;
                        end
                    endcase
                end
                S_DIV:
                begin
                    rem_reg  <= rem_ge ? WORD_W'(rem_sh - {1'b0, dvs_reg})
                                       : rem_sh[WORD_W-1:0];
                    quo_reg  <= {quo_reg[WORD_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + DCW'(1);
                end
                S_DIVFIN:
                begin
                    r_reg <= neg_reg ? (~quo_reg + WORD_W'(1)) : quo_reg;
                end
                S_WB:
                begin
                    count_reg          <= cnt_m1;
                    pend_reg.out_value <= r_reg;
                    pend_reg.status    <= ST_OK;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        res_reg <= pend_reg;
                    end
                end
                S_DRN:
                begin
                    if (out_free)
                    begin
                        res_reg.out_value <= rd_data_reg;
                        res_reg.status    <= ST_OK;
                        res_reg.last      <= drn_last;
                        if (drn_last)
                        begin
                            count_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= AW'(CW'(idx_reg) + CW'(1));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
